[hdl/tksil_pkg.sv]
// ----------------------------------------------------------------------------
// tksil_pkg: shared types and constants of the top-K sorted insertion list
// Holds the record type, the per-cell control group, the operation codes,
// the controller states and the beat layout constants.
// ----------------------------------------------------------------------------
package tksil_pkg;

	localparam int DEFAULT_DEPTH = 256;

	// Field widths of one input beat and one result beat.
	localparam int FUNC_W  = 2;
	localparam int WORD_W  = 32;
	localparam int IDX_W   = 8;
	localparam int COUNT_W = 9;
	localparam int RANK_W  = 8;

	localparam int S_DATA_W = 104;
	localparam int M_DATA_W = 120;

	// Cells are gathered in fixed groups for the two-stage result selector.
	localparam int GRP_SIZE = 16;
	localparam int GRP_W    = 4;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_READ   = 2'd1,
		FN_CLEAR  = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef struct packed {
		logic [WORD_W-1:0] stamp;
		logic [WORD_W-1:0] tag;
		logic [WORD_W-1:0] score;
	} rec_t;

	typedef struct packed {
		logic ins;
		logic clr;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PICK1,
		ST_PICK2,
		ST_OUT
	} state_t;

endpackage

[hdl/tksil_cell.sv]
// ----------------------------------------------------------------------------
// tksil_cell: one slot of the sorted list
// Compares the incoming score with its own entry and either keeps its entry,
// takes the new record, or takes its upper neighbor's entry on a shift; a clear empties it.
// ----------------------------------------------------------------------------
module tksil_cell
	import tksil_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  rec_t      new_rec,
	input  rec_t      prev_rec,
	input  logic      prev_valid,
	input  logic      prev_take,
	output rec_t      rec,
	output logic      valid,
	output logic      take
);

	rec_t rec_q;
	logic valid_q;

	// The list is sorted and valid entries form a prefix, so take is monotone
	// along the chain: the first cell with take set is the insert position.
	assign take  = ctl.ins && (!valid_q || (new_rec.score > rec_q.score));
	assign rec   = rec_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= prev_take ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rec_q <= prev_take ? prev_rec : new_rec;
		end
	end

endmodule

[hdl/tksil_pick.sv]
// ----------------------------------------------------------------------------
// tksil_pick: two-stage registered selector over the cell row
// Stage one works inside groups of cells, stage two across the groups; it
// returns the entry at the read index and the first cell that took an insert.
// ----------------------------------------------------------------------------
module tksil_pick
	import tksil_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic              clk,
	input  rec_t              cells [DEPTH],
	input  logic [DEPTH-1:0]  take,
	input  logic [IDX_W-1:0]  index,
	output rec_t              rd_rec,
	output logic [RANK_W-1:0] rank
);

	localparam int NG   = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
	localparam int NG2  = 1 << GW;
	localparam int PADN = NG2 * GRP_SIZE;
	localparam int XW   = (IDX_W > GRP_W + GW) ? IDX_W : GRP_W + GW;

	rec_t             pad      [PADN];
	logic [PADN-1:0]  take_pad;
	logic [XW-1:0]    idx_x;
	logic [GRP_W-1:0] lo;
	logic [GW-1:0]    hi;

	rec_t             rd_s1    [NG2];
	logic             any_s1   [NG2];
	logic [GRP_W-1:0] first_s1 [NG2];

	rec_t                rd_s2;
	logic [GRP_W+GW-1:0] rank_s2;

	// Lowest set bit of one group; all-zero groups are masked by any_s1.
	function automatic logic [GRP_W-1:0] first_set(input logic [GRP_SIZE-1:0] v);
		logic [GRP_W-1:0] r;
		r = '0;
		for (int b = GRP_SIZE - 1; b >= 0; b--) begin
			if (v[b]) begin
				r = GRP_W'(b);
			end
		end
		return r;
	endfunction

	genvar i;
	generate
		for (i = 0; i < PADN; i++) begin : g_pad
			if (i < DEPTH) begin : g_real
				assign pad[i]      = cells[i];
				assign take_pad[i] = take[i];
			end else begin : g_fill
				assign pad[i]      = '0;
				assign take_pad[i] = 1'b0;
			end
		end
	endgenerate

	assign idx_x = XW'(index);
	assign lo    = idx_x[GRP_W-1:0];
	assign hi    = idx_x[GRP_W +: GW];

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG2; g++) begin
			rd_s1[g]    <= pad[g * GRP_SIZE + int'(lo)];
			any_s1[g]   <= |take_pad[g * GRP_SIZE +: GRP_SIZE];
			first_s1[g] <= first_set(take_pad[g * GRP_SIZE +: GRP_SIZE]);
		end
	end

	always_ff @(posedge clk) begin
		logic [GW-1:0] sel;
		sel = '0;
		for (int g = NG2 - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				sel = GW'(g);
			end
		end
		rd_s2   <= rd_s1[hi];
		rank_s2 <= {sel, first_s1[sel]};
	end

	assign rd_rec = rd_s2;
	assign rank   = RANK_W'(rank_s2);

endmodule

[hdl/top_k_sorted_insert_list_core.sv]
// ----------------------------------------------------------------------------
// top_k_sorted_insert_list_core: top-K sorted insertion list
// Keeps up to LIST_DEPTH records in descending score order in a row of cells
// and answers insert, read, clear and idle operations with one result beat each.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents (lowest bits first)
//  -------  ---------  ------------------------------------------------------
//  s_*      in         tdata: score, tag, stamp, index; tuser: func
//  m_*      out        tdata: entry_count, accepted, rank, read_valid,
//                      read_score, read_tag, read_stamp, zero fill
//
// All cells compare and shift at the edge that accepts an input beat. The
// result then passes the registered stages of the group selector while the
// controller steps through ST_PICK1 and ST_PICK2, and the result beat is
// offered in ST_OUT. The block takes one item at a time; s_tready returns
// the cycle after the result beat is taken, so a stalled m_tready holds the
// input side as well. Reset clears every cell's valid bit and the entry
// count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_list_core
	import tksil_pkg::*;
#(
	parameter int LIST_DEPTH = DEFAULT_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // score[31:0], tag[63:32], stamp[95:64], index[103:96]
	input  logic [FUNC_W-1:0]   s_tuser,   // func[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // entry_count[8:0], accepted[9], rank[17:10],
	                                       // read_valid[18], read_score[50:19],
	                                       // read_tag[82:51], read_stamp[114:83], zero[119:115]
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	// Input beat fields.
	func_t            in_func;
	rec_t             in_rec;
	logic [IDX_W-1:0] in_index;
	logic             in_beat;

	assign in_func       = func_t'(s_tuser);
	assign in_rec.score  = s_tdata[31:0];
	assign in_rec.tag    = s_tdata[63:32];
	assign in_rec.stamp  = s_tdata[95:64];
	assign in_index      = s_tdata[103:96];
	assign in_beat       = s_tvalid && s_tready;

	state_t state_q, state_nxt;

	// Cell row. Each cell sees only the incoming record and its upper
	// neighbor, so an insert and the shift below it finish together at the edge that accepts the beat.
	cell_ctl_t             ctl;
	rec_t                  cell_rec   [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] cell_valid;
	logic [LIST_DEPTH-1:0] cell_take;

	// A zero score is never placed, so it never raises the insert strobe.
	assign ctl.ins = in_beat && (in_func == FN_INSERT) && (in_rec.score != '0);
	assign ctl.clr = in_beat && (in_func == FN_CLEAR);

	genvar i;
	generate
		for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
			if (i == 0) begin : g_head
				tksil_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctl        (ctl),
					.new_rec    (in_rec),
					.prev_rec   ('0),
					.prev_valid (1'b0),
					.prev_take  (1'b0),
					.rec        (cell_rec[i]),
					.valid      (cell_valid[i]),
					.take       (cell_take[i])
				);
			end else begin : g_body
				tksil_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctl        (ctl),
					.new_rec    (in_rec),
					.prev_rec   (cell_rec[i-1]),
					.prev_valid (cell_valid[i-1]),
					.prev_take  (cell_take[i-1]),
					.rec        (cell_rec[i]),
					.valid      (cell_valid[i]),
					.take       (cell_take[i])
				);
			end
		end
	endgenerate

	// Per-operation result state, captured with the accepted input beat.
	logic [CNT_W-1:0]      count_q;
	logic [LIST_DEPTH-1:0] take_q;
	logic [IDX_W-1:0]      index_q;
	logic                  accepted_q;
	logic                  rd_ok_q;

	// Because take is monotone, the last cell's take says whether any cell
	// took the record, whether the list was full or not.
	logic accept_now;
	logic rd_ok_now;

	assign accept_now = cell_take[LIST_DEPTH-1];
	assign rd_ok_now  = (in_func == FN_READ) && (CMP_W'(in_index) < CMP_W'(count_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			accepted_q <= 1'b0;
			rd_ok_q    <= 1'b0;
		end else if (in_beat) begin
			accepted_q <= accept_now;
			rd_ok_q    <= rd_ok_now;
			if (ctl.clr) begin
				count_q <= '0;
			end else if (accept_now && (count_q != CNT_W'(LIST_DEPTH))) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			take_q  <= cell_take;
			index_q <= in_index;
		end
	end

	// Result selection: read entry and landing position of an insert.
	rec_t              pick_rec;
	logic [RANK_W-1:0] pick_rank;

	tksil_pick #(
		.DEPTH (LIST_DEPTH)
	) u_pick (
		.clk    (clk),
		.cells  (cell_rec),
		.take   (take_q),
		.index  (index_q),
		.rd_rec (pick_rec),
		.rank   (pick_rank)
	);

	// Controller: idle, the selector states ST_PICK1 and ST_PICK2, then hold the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nxt = ST_PICK1;
				end
			end
			ST_PICK1: begin
				state_nxt = ST_PICK2;
			end
			ST_PICK2: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Result beat. The cells, take_q and index_q hold still until the beat
	// is taken, so the selector output stays stable while the beat waits.
	rec_t              out_rec;
	logic [RANK_W-1:0] out_rank;

	assign out_rec  = rd_ok_q ? pick_rec : '0;
	assign out_rank = accepted_q ? pick_rank : '0;

	assign m_tdata = {
		5'd0,
		out_rec.stamp,
		out_rec.tag,
		out_rec.score,
		rd_ok_q,
		out_rank,
		accepted_q,
		COUNT_W'(count_q)
	};

endmodule

[tb/tksil_list_checker.sv]
// ----------------------------------------------------------------------------
// tksil_list_checker: result checker for the top-K sorted insertion list
// Watches both stream channels, keeps its own copy of the sorted list, works
// out the result beat for every accepted input beat and compares the result
// beats in order, field by field.
// ----------------------------------------------------------------------------
module tksil_list_checker
	import tksil_pkg::*;
#(
	parameter int LIST_DEPTH = DEFAULT_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // score[31:0], tag[63:32], stamp[95:64], index[103:96]
	input  logic [FUNC_W-1:0]   s_tuser,   // func[1:0]
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,   // entry_count, accepted, rank, read_valid,
	                                       // read_score, read_tag, read_stamp, zero fill
	input  logic                drain_done,
	output int                  failures
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FILL_W       = M_DATA_W - COUNT_W - RANK_W - 2 - 3 * WORD_W;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] stamp;
		logic [WORD_W-1:0] tag;
		logic [WORD_W-1:0] score;
	} list_op_t;

	typedef struct packed {
		logic [FILL_W-1:0]  fill;
		logic [WORD_W-1:0]  read_stamp;
		logic [WORD_W-1:0]  read_tag;
		logic [WORD_W-1:0]  read_score;
		logic               read_valid;
		logic [RANK_W-1:0]  rank;
		logic               accepted;
		logic [COUNT_W-1:0] entry_count;
	} list_result_t;

	rec_t         shadow_list [LIST_DEPTH];
	int unsigned  shadow_count;
	list_result_t expected_results [$];
	int           beat_no;
	bit           drained;

	// Applies one operation to the shadow list and returns the result beat it causes.
	function automatic list_result_t apply_list_op(func_t fn, list_op_t op);
		list_result_t res;
		int unsigned  pos;
		int unsigned  last;
		int unsigned  j;
		res = '0;
		case (fn)
			FN_INSERT: begin
				if (op.score != '0) begin
					// Equal scores stay ahead, so the new record lands after them.
					pos = 0;
					while (pos < shadow_count && !(op.score > shadow_list[pos].score))
						pos++;
					if (pos < LIST_DEPTH) begin
						last = (shadow_count < LIST_DEPTH) ? shadow_count : LIST_DEPTH - 1;
						for (j = last; j > pos; j--)
							shadow_list[j] = shadow_list[j - 1];
						shadow_list[pos] = '{stamp: op.stamp, tag: op.tag, score: op.score};
						if (shadow_count < LIST_DEPTH)
							shadow_count++;
						res.accepted = 1'b1;
						res.rank     = RANK_W'(pos);
					end
				end
			end
			FN_READ: begin
				if (op.index < shadow_count) begin
					res.read_valid = 1'b1;
					res.read_score = shadow_list[op.index].score;
					res.read_tag   = shadow_list[op.index].tag;
					res.read_stamp = shadow_list[op.index].stamp;
				end
			end
			FN_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		res.entry_count = COUNT_W'(shadow_count);
		return res;
	endfunction

	task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		if (got !== want) begin
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("%t result beat %0d: %s expected %0h, got %0h",
					$time, beat_no, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		list_result_t got;
		if (!arst_n) begin
			foreach (shadow_list[i])
				shadow_list[i] = '0;
			shadow_count = 0;
			expected_results.delete();
			failures = 0;
			beat_no  = 0;
			drained  = 1'b0;
		end else begin
			// Results are taken before new work, as a beat cannot cause a result in its own cycle.
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("%t result beat %0d arrived with nothing expected: %0h",
							$time, beat_no, got);
				end else begin
					want = expected_results.pop_front();
					check_field("entry_count", WORD_W'(want.entry_count),
						WORD_W'(got.entry_count));
					check_field("accepted", WORD_W'(want.accepted), WORD_W'(got.accepted));
					check_field("rank", WORD_W'(want.rank), WORD_W'(got.rank));
					check_field("read_valid", WORD_W'(want.read_valid),
						WORD_W'(got.read_valid));
					check_field("read_score",  want.read_score,  got.read_score);
					check_field("read_tag",    want.read_tag,    got.read_tag);
					check_field("read_stamp",  want.read_stamp,  got.read_stamp);
					check_field("fill", WORD_W'(want.fill), WORD_W'(got.fill));
				end
				beat_no++;
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_list_op(func_t'(s_tuser), s_tdata));
			if (drain_done && !drained) begin
				drained = 1'b1;
				if (expected_results.size() != 0) begin
					failures += expected_results.size();
					$display("%t %0d result beats never arrived", $time, expected_results.size());
				end
			end
		end
	end

endmodule

[tb/top_k_sorted_insert_list_core_tb.sv]
// ----------------------------------------------------------------------------
// top_k_sorted_insert_list_core_tb: testbench of the top-K sorted insertion list
// Drives insert, read, clear and idle operations into the block, first a
// directed set of corner cases and then three random phases, the first two of
// which fill the list past its depth, stall both channels at random and gives the
// verdict from the failure count of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_list_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tksil_pkg::*;

	localparam int LIST_DEPTH     = DEFAULT_DEPTH;
	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 8;
	// Random phases: a wide-score fill, a narrow-score fill full of ties, and a
	// mixed phase with clears.
	localparam int RANDOM_OPS     = 1100;
	localparam int PHASE_B_START  = 450;
	localparam int PHASE_C_START  = 900;
	// The receiver stops taking beats for a long stretch once, at this result.
	localparam int HOLD_AT        = 600;
	localparam int HOLD_CYCLES    = 300;
	// The limit lies above the slowest correct stretch without a beat on either
	// side, the long receiver hold included.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;   // score[31:0], tag[63:32], stamp[95:64], index[103:96]
	logic [FUNC_W-1:0]   s_tuser;   // func[1:0]
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;   // entry_count, accepted, rank, read_valid,
	                                // read_score, read_tag, read_stamp, zero fill
	logic                drain_done;
	int                  failures;

	// Beats moved on each side, and the number of entries the list holds as
	// seen from the stimulus side; the latter only steers read indexes.
	int sent_count = 0;
	int recv_count = 0;
	int list_fill  = 0;

	always #CLK_HALF clk = ~clk;

	top_k_sorted_insert_list_core #(
		.LIST_DEPTH(LIST_DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	tksil_list_checker #(
		.LIST_DEPTH(LIST_DEPTH)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.drain_done(drain_done),
		.failures  (failures)
	);

	// Offers one beat on the input channel. It is called at a falling edge and
	// returns at the falling edge after the beat was taken. Every fourth run of
	// fifty beats goes without gaps, the rest draw a random gap before the beat.
	task automatic offer_op(func_t fn, logic [WORD_W-1:0] score, logic [WORD_W-1:0] tag,
			logic [WORD_W-1:0] stamp, logic [IDX_W-1:0] idx);
		int gap;
		gap = ((sent_count / 50) % 4 == 3) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {idx, stamp, tag, score};
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		sent_count++;
		// Below the depth a nonzero score always finds a place.
		case (fn)
			FN_INSERT: begin
				if (score != '0 && list_fill < LIST_DEPTH)
					list_fill++;
			end
			FN_CLEAR: begin
				list_fill = 0;
			end
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	// Draws one random operation shaped by the phase. The fields an operation
	// does not use still carry random values, so they are seen to be ignored.
	task automatic send_random_op(int phase);
		int                r;
		int                pick;
		func_t             fn;
		logic [WORD_W-1:0] score;
		logic [WORD_W-1:0] tag;
		logic [WORD_W-1:0] stamp;
		logic [IDX_W-1:0]  idx;
		r     = $urandom_range(0, 99);
		pick  = $urandom_range(0, 19);
		score = $urandom;
		tag   = $urandom;
		stamp = $urandom;
		idx   = IDX_W'($urandom_range(0, 255));
		if (phase == 2) begin
			if (r < 50)
				fn = FN_INSERT;
			else if (r < 90)
				fn = FN_READ;
			else if (r < 94)
				fn = FN_CLEAR;
			else
				fn = FN_NOP;
		end else begin
			if (r < 75)
				fn = FN_INSERT;
			else if (r < 96)
				fn = FN_READ;
			else
				fn = FN_NOP;
		end
		if (fn == FN_INSERT) begin
			if (phase == 1) begin
				// Scores from a tiny range: long runs of ties, and once the list
				// is full most inserts tie with or fall below the last entry.
				if (pick < 16)
					score = $urandom_range(1, 8);
				else if (pick == 19)
					score = '0;
			end else begin
				if (pick < 8)
					score = $urandom_range(1, 24);
				else if (pick < 16)
					score = $urandom;
				else if (pick < 18)
					score = '0;
				else if (pick == 18)
					score = '1;
				else
					score = 32'd1;
			end
		end
		// Most reads hit a filled slot, the rest may land past the end.
		if (fn == FN_READ && list_fill > 0 && $urandom_range(0, 9) < 7)
			idx = IDX_W'($urandom_range(0, list_fill - 1));
		offer_op(fn, score, tag, stamp, idx);
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = FN_NOP;
		drain_done = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reads and an idle operation on the empty list return nothing.
		offer_op(FN_READ,   '0, '0, '0, 8'd0);
		offer_op(FN_READ,   '1, '1, '1, 8'd255);
		offer_op(FN_NOP,    '0, '0, '0, 8'd0);
		// A zero score is dropped.
		offer_op(FN_INSERT, '0, '1, '1, '1);
		// Highest score into the empty list, then the lowest is appended at the end.
		offer_op(FN_INSERT, '1, '1, '1, '0);
		offer_op(FN_INSERT, 32'd1, 32'd1, 32'd1, 8'd0);
		// Two equal scores land in arrival order between the two.
		offer_op(FN_INSERT, 32'd100, 32'h0000_000a, 32'h1111_1111, 8'd0);
		offer_op(FN_INSERT, 32'd100, 32'h0000_000b, 32'h2222_2222, 8'd0);
		// A tie with the top entry goes right below it.
		offer_op(FN_INSERT, '1, 32'h0000_000c, 32'h3333_3333, 8'd0);
		for (int i = 0; i < 6; i++)
			offer_op(FN_READ, '0, '0, '0, IDX_W'(i));
		offer_op(FN_READ,   '0, '0, '0, 8'd255);
		offer_op(FN_NOP,    '1, '1, '1, '1);
		// Clear, after which nothing is readable, then refill.
		offer_op(FN_CLEAR,  '1, '1, '1, '1);
		offer_op(FN_READ,   '0, '0, '0, 8'd0);
		offer_op(FN_INSERT, 32'd1, '0, '0, '0);
		offer_op(FN_READ,   '0, '0, '0, 8'd0);
		offer_op(FN_CLEAR,  '0, '0, '0, '0);

		// Random phases; the narrow-score phase starts from an empty list.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == PHASE_B_START)
				offer_op(FN_CLEAR, $urandom, $urandom, $urandom,
					IDX_W'($urandom_range(0, 255)));
			if (n < PHASE_B_START)
				send_random_op(0);
			else if (n < PHASE_C_START)
				send_random_op(1);
			else
				send_random_op(2);
		end
		s_tvalid <= 1'b0;

		// Wait for every result, then a little longer to catch stray beats.
		wait (recv_count == sent_count);
		repeat (DRAIN_CYCLES) @(negedge clk);
		drain_done <= 1'b1;
		@(negedge clk);
		if (failures == 0)
			$display("** top_k_sorted_insert_list_core: PASSED **");
		else
			$display("** top_k_sorted_insert_list_core: FAILED **");
		$finish;
	end

	// Result side. Each beat is preceded by a random stall, except in every fifth
	// run of forty beats. Once, the receiver stops for a long stretch while the
	// sender keeps offering, so the block fills up and holds its input side.
	initial begin
		int  stall;
		bit  held;
		m_tready = 1'b0;
		held     = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (recv_count == HOLD_AT && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = ((recv_count / 40) % 5 == 2) ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!(m_tvalid && m_tready));
			recv_count++;
			@(negedge clk);
		end
	end

	// Ends a run that has stopped moving: no beat on either side for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("** top_k_sorted_insert_list_core: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
hdl/tksil_pkg.sv
hdl/tksil_cell.sv
hdl/tksil_pick.sv
hdl/top_k_sorted_insert_list_core.sv
tb/tksil_list_checker.sv
tb/top_k_sorted_insert_list_core_tb.sv
